// File: src/packet_spec_tokenizer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet spec tokenizer
// Shared property templates used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PACKET_SPEC_TOKENIZER_CORE_DEFINES_SVH
`define PACKET_SPEC_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Token codes, queue entry type and keyword matcher for the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

    localparam int TOK_W  = 4;
    localparam int LINE_W = 16;
    localparam int CH_W   = 8;

    localparam logic [TOK_W-1:0] TK_PACKET   = 4'd0;
    localparam logic [TOK_W-1:0] TK_STRING   = 4'd6;
    localparam logic [TOK_W-1:0] TK_LBRACE   = 4'd7;
    localparam logic [TOK_W-1:0] TK_RBRACE   = 4'd8;
    localparam logic [TOK_W-1:0] TK_LBRACKET = 4'd9;
    localparam logic [TOK_W-1:0] TK_RBRACKET = 4'd10;
    localparam logic [TOK_W-1:0] TK_SEMI     = 4'd11;
    localparam logic [TOK_W-1:0] TK_EQUALS   = 4'd12;
    localparam logic [TOK_W-1:0] TK_END      = 4'd13;
    localparam logic [TOK_W-1:0] TK_ERROR    = 4'd14;

    localparam int KW_NUM = 7;
    localparam int KW_MAX = 6;

    // character i of each keyword sits at index i, unused tail is zero
    localparam logic [0:KW_MAX-1][7:0] KW_TEXT [KW_NUM] = '{
        "packet",
        {"u8", 32'h0},
        {"u16be", 8'h0},
        {"u16le", 8'h0},
        {"u32be", 8'h0},
        {"u32le", 8'h0},
        "string"
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd6, 3'd2, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6};

    // queue depth between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // one or two tokens caused by a single character
    typedef struct packed {
        logic              two;
        logic [TOK_W-1:0]  tok_a;
        logic [TOK_W-1:0]  tok_b;
        logic [LINE_W-1:0] line;
    } pst_entry_t;

    function automatic logic [TOK_W-1:0] kw_match(input logic [KW_MAX-1:0][7:0] wbuf,
                                                  input logic [2:0] len);
        logic [TOK_W-1:0] res;
        logic             eq;
        res = TK_ERROR;
        for (int k = KW_NUM - 1; k >= 0; k--)
        begin
            eq = (len == KW_LEN[k]);
            for (int i = 0; i < KW_MAX; i++)
            begin
                if ((3'(i) < KW_LEN[k]) && (wbuf[i] != KW_TEXT[k][i]))
                    eq = 1'b0;
            end
            if (eq)
                res = TOK_W'(k);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: src/pst_front.sv
// ----------------------------------------------------------------------------
// pst_front
// Accepts one character a cycle while the queue has room, tracks scan mode and line, builds tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_front
    import pst_pkg::*;
#(
    parameter int LINE_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CH_W-1:0]   ch,
    input  wire logic              cfg_we,
    input  wire logic [LINE_W-1:0] cfg_data,
    output logic                   push,
    output pst_entry_t             push_entry,
    input  wire logic              q_ready
);

    typedef enum logic [1:0] {MODE_IDLE, MODE_WORD, MODE_SLASH, MODE_COMMENT} mode_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    mode_t                      mode_reg, mode_next;
    logic [2:0]                 len_reg, len_next;
    logic [LINE_BITS-1:0]       line_reg, line_next;
    logic [KW_MAX-1:0][7:0]     wbuf_reg;
    logic [LINE_BITS-1:0]       cfg_line;
    logic [LINE_W-1:0]          line_out;

    logic       accept;
    logic       is_alpha, is_start, is_word, is_digit;
    logic       idle_emit, idle_nl;
    logic [3:0] idle_tok;
    mode_t      idle_mode;
    logic       line_inc, wr_en, wr_first;
    logic [1:0] n_tok;
    logic [3:0] tok_a, tok_b;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    generate
        if (LINE_BITS > LINE_W)
        begin : g_wide
            assign line_out = (|line_reg[LINE_BITS-1:LINE_W]) ? {LINE_W{1'b1}}
                                                              : line_reg[LINE_W-1:0];
            assign cfg_line = LINE_BITS'(cfg_data);
        end
        else if (LINE_BITS < LINE_W)
        begin : g_narrow
            assign line_out = LINE_W'(line_reg);
            assign cfg_line = (|cfg_data[LINE_W-1:LINE_BITS]) ? LINE_MAX
                                                              : cfg_data[LINE_BITS-1:0];
        end
        else
        begin : g_equal
            assign line_out = LINE_W'(line_reg);
            assign cfg_line = LINE_BITS'(cfg_data);
        end
    endgenerate

    assign is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_start = is_alpha || (ch == CH_UNDER);
    assign is_word  = is_start || is_digit;

    // what a character does when nothing is pending
    always_comb
    begin
        idle_emit = 1'b0;
        idle_nl   = 1'b0;
        idle_tok  = TK_ERROR;
        idle_mode = MODE_IDLE;
        priority if ((ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR))
            idle_emit = 1'b0;
        else if (ch == CH_LF)
            idle_nl = 1'b1;
        else if (is_start)
            idle_mode = MODE_WORD;
        else if (ch == CH_SLASH)
            idle_mode = MODE_SLASH;
        else
        begin
            idle_emit = 1'b1;
            unique case (ch)
                CH_LBRC: idle_tok = TK_LBRACE;
                CH_RBRC: idle_tok = TK_RBRACE;
                CH_LBRK: idle_tok = TK_LBRACKET;
                CH_RBRK: idle_tok = TK_RBRACKET;
                CH_SEMI: idle_tok = TK_SEMI;
                CH_EQ:   idle_tok = TK_EQUALS;
                CH_NUL:  idle_tok = TK_END;
                default: idle_tok = TK_ERROR;
            endcase
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        line_inc  = 1'b0;
        wr_en     = 1'b0;
        wr_first  = 1'b0;
        n_tok     = 2'd0;
        tok_a     = idle_tok;
        tok_b     = idle_tok;
        unique case (mode_reg)
            MODE_WORD:
            begin
                if (is_word)
                begin
                    wr_en = (len_reg < 3'd6);
                    if (len_reg != 3'd7)
                        len_next = len_reg + 3'd1;
                end
                else
                begin
                    // word ends: keep its token, then treat the char as fresh
                    tok_a     = kw_match(wbuf_reg, len_reg);
                    n_tok     = idle_emit ? 2'd2 : 2'd1;
                    mode_next = idle_mode;
                    line_inc  = idle_nl;
                    wr_first  = (idle_mode == MODE_WORD);
                    len_next  = wr_first ? 3'd1 : 3'd0;
                end
            end
            MODE_SLASH:
            begin
                if (ch == CH_SLASH)
                    mode_next = MODE_COMMENT;
                else
                begin
                    tok_a     = TK_ERROR;
                    n_tok     = idle_emit ? 2'd2 : 2'd1;
                    mode_next = idle_mode;
                    line_inc  = idle_nl;
                    wr_first  = (idle_mode == MODE_WORD);
                    len_next  = wr_first ? 3'd1 : 3'd0;
                end
            end
            MODE_COMMENT:
            begin
                if (ch == CH_LF)
                begin
                    line_inc  = 1'b1;
                    mode_next = MODE_IDLE;
                end
                else if (ch == CH_NUL)
                begin
                    tok_a     = TK_END;
                    n_tok     = 2'd1;
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                tok_a     = idle_tok;
                n_tok     = idle_emit ? 2'd1 : 2'd0;
                mode_next = idle_mode;
                line_inc  = idle_nl;
                wr_first  = (idle_mode == MODE_WORD);
                len_next  = wr_first ? 3'd1 : 3'd0;
            end
        endcase
    end

    assign line_next = (line_inc && (line_reg != LINE_MAX)) ? line_reg + 1'b1 : line_reg;

    assign push             = accept && (n_tok != 2'd0);
    assign push_entry.two   = (n_tok == 2'd2);
    assign push_entry.tok_a = tok_a;
    assign push_entry.tok_b = tok_b;
    assign push_entry.line  = line_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            len_reg  <= 3'd0;
            line_reg <= LINE_BITS'(1);
        end
        else if (cfg_we)
        begin
            line_reg <= cfg_line;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            line_reg <= line_next;
        end
    end

    // word text, only entries below the length are ever matched
    always_ff @(posedge clk)
    begin
        if (accept && wr_first)
            wbuf_reg[0] <= ch;
        else if (accept && wr_en)
            wbuf_reg[len_reg] <= ch;
    end

endmodule

`default_nettype wire

// File: src/pst_queue.sv
// ----------------------------------------------------------------------------
// pst_queue
// Short FIFO of token entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_queue
    import pst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire pst_entry_t  push_entry,
    output logic             ready,
    output logic             nonempty,
    output pst_entry_t       head,
    input  wire logic        pop
);

    pst_entry_t         mem [Q_DEPTH];
    logic [Q_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]      count_reg, count_next;

    assign ready    = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// File: src/pst_back.sv
// ----------------------------------------------------------------------------
// pst_back
// Output register: plays each entry out as one or two words.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_back
    import pst_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_nonempty,
    input  wire pst_entry_t                  q_head,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [TOK_W+LINE_W+3:0]          m_tdata,
    output logic                             m_tlast
);

    logic        valid_reg;
    logic        phase_reg;
    pst_entry_t  cur_reg;
    logic        final_word;
    logic        out_free;

    assign final_word = phase_reg || !cur_reg.two;
    assign out_free   = !valid_reg || (m_tready && final_word);
    assign q_pop      = out_free && q_nonempty;

    assign m_tvalid = valid_reg;
    assign m_tlast  = final_word;
    assign m_tdata  = {4'b0, cur_reg.line, (phase_reg ? cur_reg.tok_b : cur_reg.tok_a)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            phase_reg <= 1'b0;
        end
        else if (valid_reg && m_tready)
        begin
            // advance to the second word, or drop the finished entry
            if (final_word)
                valid_reg <= 1'b0;
            else
                phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_head;
    end

endmodule

`default_nettype wire

// File: src/packet_spec_tokenizer_core.sv
// ----------------------------------------------------------------------------
// packet_spec_tokenizer_core
// Streaming lexer for the packet layout language, one character per word.
// ----------------------------------------------------------------------------
// The first token of a character passes through the queue and then the output register before it shows on m_tvalid.
// Throughput: one character per cycle while the queue has room; a character that closes a word or a slash and
// is itself a token occupies the output for two words, and the 4-entry queue absorbs it.
// Reset: scan mode idle, word length zero, line 1, queue and output register empty.
// A write on cfg_we reloads the current line with cfg_data.
`default_nettype none

module packet_spec_tokenizer_core
    import pst_pkg::*;
#(
    parameter int LINE_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [3:0] token, [19:4] line_number, [23:20] zero
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data
);

    logic        push, q_ready, q_nonempty, q_pop;
    pst_entry_t  push_entry, q_head;

    pst_front #(.LINE_BITS(LINE_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .ch         (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready)
    );

    pst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .ready      (q_ready),
        .nonempty   (q_nonempty),
        .head       (q_head),
        .pop        (q_pop)
    );

    pst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// File: src/pst_checker.sv
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks on the token stream of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_spec_tokenizer_core_defines.svh"

module pst_checker
    import pst_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    `PST_ASSERT_NOW(a_tok_code, m_tvalid, m_tdata[3:0] != 4'hF, "token code out of range")

    // only a closed word or a lone slash can precede a second token
    `PST_ASSERT_NOW(a_first_of_two, m_tvalid && !m_tlast, (m_tdata[3:0] <= TK_STRING) || (m_tdata[3:0] == TK_ERROR), "unexpected first token of a pair")

    `PST_ASSERT_NEXT(a_pair_follows, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast && (m_tdata[19:4] == $past(m_tdata[19:4])), "second token of a pair missing")

    `PST_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

endmodule

bind packet_spec_tokenizer_core pst_checker u_pst_checker (.*);

`default_nettype wire
